@@ rtl/core/mwm_pkg.sv @@
`timescale 1ns / 1ps

package mwm_pkg;

  localparam int SpeedW = 16;
  localparam int GainW  = 12;
  localparam int LimitW = 15;
  localparam int LinW   = 18;
  localparam int TurnW  = 28;
  localparam int SumW   = 29;
  localparam int ProdW  = SpeedW + LimitW;
  localparam int QuotW  = LimitW;
  localparam int Lanes  = 4;

  localparam logic [GainW-1:0]  GainReset  = GainW'(998);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(8000);

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic {
    REG_GAIN  = 1'b0,
    REG_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] forward_speed;
    logic signed [SpeedW-1:0] side_speed;
    logic signed [SpeedW-1:0] turn_speed;
  } in_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] first_wheel_speed;
    logic signed [SpeedW-1:0] second_wheel_speed;
    logic signed [SpeedW-1:0] third_wheel_speed;
    logic signed [SpeedW-1:0] fourth_wheel_speed;
    logic                     was_scaled;
  } out_t;

  typedef logic [Lanes-1:0][SpeedW-1:0] wheel4_t;
  typedef logic [Lanes-1:0][ProdW-1:0]  num4_t;
  typedef logic [Lanes-1:0][QuotW-1:0]  quot4_t;

  // Carried alongside the divider: what the output stage needs to rebuild each wheel
  typedef struct packed {
    wheel4_t          wheel;
    logic [Lanes-1:0] neg;
    logic             scaled;
  } side_t;

  function automatic logic [SpeedW-1:0] mag16(input logic [SpeedW-1:0] w);
    logic [SpeedW:0] t;
    t = w[SpeedW-1] ? ((SpeedW+1)'(0) - {1'b1, w}) : {1'b0, w};
    return t[SpeedW-1:0];
  endfunction

endpackage

@@ rtl/core/mecanum_wheel_mixer_top.sv @@
`timescale 1ns / 1ps

// Mecanum wheel mixer: turns a forward/side/turn command into four wheel speed targets,
// clamped to signed 16 bits and scaled back proportionally when the largest wheel exceeds
// the programmed limit. One command is taken every clock while the pipeline is not stalled;
// each result passes through 2 mixing stages, 2 magnitude/product stages, a 15-stage
// divider that resolves one quotient bit per stage, and the output register. Stalls
// back-propagate stage by stage, so empty stages still fill while the output waits.
// Registers: 0x0 rotation gain (12 bits, unsigned Q8, reset 998), 0x4 speed limit
// (15 bits, reset 8000); program them only while no command is in flight.
module mecanum_wheel_mixer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mwm_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mwm_pkg::out_t                out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mwm_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [mwm_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [mwm_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  localparam int Lanes = mwm_pkg::Lanes;

  logic [mwm_pkg::GainW-1:0]  gain_r;
  logic [mwm_pkg::LimitW-1:0] limit_r;
  mwm_pkg::reg_idx_t          reg_idx;
  logic                       cfg_wr;

  logic                       mix_valid, mix_ready;
  mwm_pkg::wheel4_t           mix_wheel;
  logic                       norm_valid, norm_ready;
  mwm_pkg::num4_t             norm_num;
  logic [mwm_pkg::SpeedW-1:0] norm_max;
  mwm_pkg::side_t             norm_side;
  logic                       div_valid, div_ready;
  mwm_pkg::quot4_t            div_quot;
  mwm_pkg::side_t             div_side;

  logic                       out_valid_r, ld_out;
  mwm_pkg::out_t              out_data_r;
  mwm_pkg::wheel4_t           res_nxt;
  logic [mwm_pkg::SpeedW-1:0] qx;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = mwm_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= mwm_pkg::GainReset;
      limit_r <= mwm_pkg::LimitReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mwm_pkg::REG_GAIN:  gain_r  <= cfg_pwdata[mwm_pkg::GainW-1:0];
        mwm_pkg::REG_LIMIT: limit_r <= cfg_pwdata[mwm_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mwm_pkg::REG_GAIN:  cfg_prdata = mwm_pkg::CfgDataW'(gain_r);
      mwm_pkg::REG_LIMIT: cfg_prdata = mwm_pkg::CfgDataW'(limit_r);
      default:            cfg_prdata = '0;
    endcase
  end

  mwm_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_wheel (mix_wheel)
  );

  mwm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_wheel  (mix_wheel),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_num   (norm_num),
    .out_max   (norm_max),
    .out_side  (norm_side)
  );

  mwm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_num    (norm_num),
    .in_max    (norm_max),
    .in_side   (norm_side),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // Output register: restore sign on the quotient, or pass the clamped wheel through
  assign ld_out    = !out_valid_r || out_ready;
  assign div_ready = ld_out;

  always_comb begin
    qx = '0;
    for (int i = 0; i < Lanes; i++) begin
      qx = mwm_pkg::SpeedW'(div_quot[i]);
      if (!div_side.scaled) begin
        res_nxt[i] = div_side.wheel[i];
      end else if (div_side.neg[i]) begin
        res_nxt[i] = mwm_pkg::SpeedW'(0) - qx;
      end else begin
        res_nxt[i] = qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out && div_valid) begin
      out_data_r.first_wheel_speed  <= res_nxt[0];
      out_data_r.second_wheel_speed <= res_nxt[1];
      out_data_r.third_wheel_speed  <= res_nxt[2];
      out_data_r.fourth_wheel_speed <= res_nxt[3];
      out_data_r.was_scaled         <= div_side.scaled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An empty output register lets the whole chain take a new command
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

  // Whether rescaled or not, no wheel can leave above the limit
  a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      mwm_pkg::mag16(out_data_r.first_wheel_speed)  <= mwm_pkg::SpeedW'(limit_r) &&
      mwm_pkg::mag16(out_data_r.second_wheel_speed) <= mwm_pkg::SpeedW'(limit_r) &&
      mwm_pkg::mag16(out_data_r.third_wheel_speed)  <= mwm_pkg::SpeedW'(limit_r) &&
      mwm_pkg::mag16(out_data_r.fourth_wheel_speed) <= mwm_pkg::SpeedW'(limit_r))
    else $error("wheel speed above limit");

  // Rescaling only happens when some wheel was non-zero
  a_scaled_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid && div_side.scaled |-> div_side.wheel != '0)
    else $error("rescale flagged on an all-zero command");

endmodule

@@ rtl/core/mwm_mix.sv @@
`timescale 1ns / 1ps

module mwm_mix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [mwm_pkg::GainW-1:0] gain,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mwm_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mwm_pkg::wheel4_t      out_wheel
);

  localparam int Lanes = mwm_pkg::Lanes;

  logic                             va_r, vb_r;
  logic                             lda, ldb;
  logic signed [mwm_pkg::LinW-1:0]  lin_nxt [Lanes];
  logic signed [mwm_pkg::LinW-1:0]  lin_r   [Lanes];
  logic signed [mwm_pkg::SumW-1:0]  prod_nxt;
  logic signed [mwm_pkg::TurnW-1:0] turn_r;
  logic signed [mwm_pkg::LinW-1:0]  fe, se;
  logic signed [mwm_pkg::SumW-1:0]  sum   [Lanes];
  logic signed [mwm_pkg::SumW-1:0]  sumr  [Lanes];
  logic signed [mwm_pkg::SumW-1:0]  shq   [Lanes];
  mwm_pkg::wheel4_t                 wheel_nxt, wheel_r;

  assign ldb      = !vb_r || out_ready;
  assign lda      = !va_r || ldb;
  assign in_ready = lda;

  // Stage A: linear sums and the rotation product
  always_comb begin
    fe = mwm_pkg::LinW'(in_data.forward_speed);
    se = mwm_pkg::LinW'(in_data.side_speed);
    lin_nxt[0] = se - fe;
    lin_nxt[1] = fe + se;
    lin_nxt[2] = fe - se;
    lin_nxt[3] = mwm_pkg::LinW'(0) - fe - se;
    prod_nxt   = in_data.turn_speed * $signed({1'b0, gain});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (lda) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lda && in_valid) begin
      lin_r  <= lin_nxt;
      turn_r <= prod_nxt[mwm_pkg::TurnW-1:0];
    end
  end

  // Stage B: 2*(256*lin + turn)/256 == (256*lin + turn)/128, toward zero, then clamp
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      sum[i]  = (mwm_pkg::SumW'(lin_r[i]) <<< 8) + mwm_pkg::SumW'(turn_r);
      sumr[i] = sum[i] + (sum[i][mwm_pkg::SumW-1] ? mwm_pkg::SumW'(127) : mwm_pkg::SumW'(0));
      shq[i]  = sumr[i] >>> 7;
      if (shq[i] > mwm_pkg::SumW'(32767)) begin
        wheel_nxt[i] = 16'h7fff;
      end else if (shq[i] < -mwm_pkg::SumW'(32768)) begin
        wheel_nxt[i] = 16'h8000;
      end else begin
        wheel_nxt[i] = shq[i][mwm_pkg::SpeedW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ldb) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ldb && va_r) begin
      wheel_r <= wheel_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_wheel = wheel_r;

endmodule

@@ rtl/core/mwm_norm.sv @@
`timescale 1ns / 1ps

module mwm_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mwm_pkg::LimitW-1:0] limit,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mwm_pkg::wheel4_t           in_wheel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mwm_pkg::num4_t             out_num,
  output logic [mwm_pkg::SpeedW-1:0] out_max,
  output mwm_pkg::side_t             out_side
);

  localparam int Lanes = mwm_pkg::Lanes;

  logic                       vc_r, vd_r;
  logic                       ldc, ldd;
  mwm_pkg::wheel4_t           mag_nxt, mag_r, wheel_r;
  logic [Lanes-1:0]           neg_nxt, neg_r;
  logic [mwm_pkg::SpeedW-1:0] m01, m23, max_nxt, max_r, maxd_r;
  mwm_pkg::num4_t             num_nxt, num_r;
  mwm_pkg::side_t             side_r;

  assign ldd      = !vd_r || out_ready;
  assign ldc      = !vc_r || ldd;
  assign in_ready = ldc;

  // Stage C: magnitudes and the largest of the four
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag_nxt[i] = mwm_pkg::mag16(in_wheel[i]);
      neg_nxt[i] = in_wheel[i][mwm_pkg::SpeedW-1];
    end
    m01     = (mag_nxt[0] > mag_nxt[1]) ? mag_nxt[0] : mag_nxt[1];
    m23     = (mag_nxt[2] > mag_nxt[3]) ? mag_nxt[2] : mag_nxt[3];
    max_nxt = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (ldc) begin
      vc_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ldc && in_valid) begin
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      max_r   <= max_nxt;
      wheel_r <= in_wheel;
    end
  end

  // Stage D: numerators |w|*limit for the divider
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      num_nxt[i] = mwm_pkg::ProdW'(mag_r[i]) * mwm_pkg::ProdW'(limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (ldd) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ldd && vc_r) begin
      num_r         <= num_nxt;
      maxd_r        <= max_r;
      side_r.wheel  <= wheel_r;
      side_r.neg    <= neg_r;
      side_r.scaled <= ({1'b0, max_r} > (mwm_pkg::SpeedW+1)'(limit));
    end
  end

  assign out_valid = vd_r;
  assign out_num   = num_r;
  assign out_max   = maxd_r;
  assign out_side  = side_r;

endmodule

@@ rtl/core/mwm_div.sv @@
`timescale 1ns / 1ps

module mwm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mwm_pkg::num4_t             in_num,
  input  logic [mwm_pkg::SpeedW-1:0] in_max,
  input  mwm_pkg::side_t             in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mwm_pkg::quot4_t            out_quot,
  output mwm_pkg::side_t             out_side
);

  // Restoring divider, one quotient bit per stage, MSB first
  localparam int Stages = mwm_pkg::QuotW;
  localparam int Lanes  = mwm_pkg::Lanes;
  localparam int ProdW  = mwm_pkg::ProdW;

  logic [Stages-1:0]          v_r, ld;
  mwm_pkg::num4_t             n_r   [Stages-1];
  mwm_pkg::quot4_t            q_r   [Stages];
  logic [mwm_pkg::SpeedW-1:0] m_r   [Stages-1];
  mwm_pkg::side_t             sd_r  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int Bit = Stages - 1 - k;

    mwm_pkg::num4_t             n_in, n_nxt;
    mwm_pkg::quot4_t            q_in, q_nxt;
    logic [mwm_pkg::SpeedW-1:0] m_in;
    mwm_pkg::side_t             s_in;
    logic                       v_in;
    logic [ProdW-1:0]           dsh;

    if (k == 0) begin : g_first
      assign n_in = in_num;
      assign q_in = '0;
      assign m_in = in_max;
      assign s_in = in_side;
      assign v_in = in_valid;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign q_in = q_r[k-1];
      assign m_in = m_r[k-1];
      assign s_in = sd_r[k-1];
      assign v_in = v_r[k-1];
    end

    if (k == Stages - 1) begin : g_ld_last
      assign ld[k] = !v_r[k] || out_ready;
    end else begin : g_ld
      assign ld[k] = !v_r[k] || ld[k+1];
    end

    always_comb begin
      dsh   = ProdW'(m_in) << Bit;
      n_nxt = n_in;
      q_nxt = q_in;
      for (int l = 0; l < Lanes; l++) begin
        if (n_in[l] >= dsh) begin
          n_nxt[l]      = n_in[l] - dsh;
          q_nxt[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k] && v_in) begin
        q_r[k]  <= q_nxt;
        sd_r[k] <= s_in;
      end
    end

    // Last stage keeps only the quotient and side data, not the remainder or divisor
    if (k < Stages - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ld[k] && v_in) begin
          n_r[k] <= n_nxt;
          m_r[k] <= m_in;
        end
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[Stages-1];
  assign out_quot  = q_r[Stages-1];
  assign out_side  = sd_r[Stages-1];

endmodule

@@ bench/tb_mecanum_wheel_mixer_top.sv @@
`timescale 1ns / 1ps

class wheel_mix_scoreboard;
  int unsigned gain;
  int unsigned limit;
  int fails;
  mwm_pkg::out_t wheels_due[$];

  function new();
    gain = mwm_pkg::GainReset;
    limit = mwm_pkg::LimitReset;
    fails = 0;
  endfunction

  // Exact mix, saturate, then proportional rescale against the limit
  function mwm_pkg::out_t mix(mwm_pkg::in_t cmd);
    longint f, s, t, turn, mx, mag, lim;
    longint lin[4];
    longint w[4];
    mwm_pkg::out_t r;
    f = longint'(cmd.forward_speed);
    s = longint'(cmd.side_speed);
    t = longint'(cmd.turn_speed);
    turn = t * longint'(gain);
    lin[0] = -f + s;
    lin[1] = f + s;
    lin[2] = f - s;
    lin[3] = -f - s;
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      // signed division truncates toward zero
      w[i] = ((lin[i] * 256 + turn) * 2) / 256;
      if (w[i] > 32767) w[i] = 32767;
      if (w[i] < -32768) w[i] = -32768;
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > mx) mx = mag;
    end
    lim = longint'(limit);
    r.was_scaled = (mx > lim);
    if (mx > lim) begin
      for (int i = 0; i < 4; i++) w[i] = (w[i] * lim) / mx;
    end
    r.first_wheel_speed  = 16'(w[0]);
    r.second_wheel_speed = 16'(w[1]);
    r.third_wheel_speed  = 16'(w[2]);
    r.fourth_wheel_speed = 16'(w[3]);
    return r;
  endfunction

  function void note_command(mwm_pkg::in_t cmd);
    wheels_due.push_back(mix(cmd));
  endfunction

  function void compare(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function void check_wheels(mwm_pkg::out_t got);
    mwm_pkg::out_t want;
    if (wheels_due.size() == 0) begin
      $error("wheel result with no command outstanding");
      fails++;
      return;
    end
    want = wheels_due.pop_front();
    compare("first_wheel_speed", want.first_wheel_speed, got.first_wheel_speed);
    compare("second_wheel_speed", want.second_wheel_speed, got.second_wheel_speed);
    compare("third_wheel_speed", want.third_wheel_speed, got.third_wheel_speed);
    compare("fourth_wheel_speed", want.fourth_wheel_speed, got.fourth_wheel_speed);
    compare("was_scaled", want.was_scaled, got.was_scaled);
  endfunction

  function int pending();
    return wheels_due.size();
  endfunction
endclass

module tb_mecanum_wheel_mixer_top;
  import mwm_pkg::*;

  localparam int DrainWait  = 30;
  localparam int QuietLimit = 4000;
  localparam int PhaseItems = 70;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  logic gaps_on;
  int   quiet_cycles;
  wheel_mix_scoreboard sb;

  mecanum_wheel_mixer_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_command(in_data);
    if (rst_n && out_valid && out_ready) sb.check_wheels(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic in_t mk(input int f, input int s, input int t);
    in_t c;
    c.forward_speed = 16'(f);
    c.side_speed    = 16'(s);
    c.turn_speed    = 16'(t);
    return c;
  endfunction

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(2000)) - 1000);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return 16'(int'($urandom_range(16000)) - 8000);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid still high so a following call can keep the stream going.
  task automatic send_cmd(input in_t cmd);
    while (gaps_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) send_cmd(mk(rand_speed(), rand_speed(), rand_speed()));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic cfg_access(input reg_idx_t idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CfgAddrW'(4 * int'(idx));
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic verify_reg(input reg_idx_t idx);
    logic [31:0] rd;
    logic [31:0] want;
    cfg_access(idx, 1'b0, '0, rd);
    want = (idx == REG_GAIN) ? sb.gain : sb.limit;
    if (rd !== want) begin
      $error("register %s: expected %0d, got %0d", idx.name(), want, rd);
      sb.fails++;
    end
  endtask

  // upper bits are junk on purpose: only the register width should stick
  task automatic set_and_verify(input reg_idx_t idx, input int unsigned value);
    logic [31:0] rd;
    logic [31:0] wdata;
    if (idx == REG_GAIN) begin
      wdata = ($urandom & 32'hffff_f000) | (value & 32'h0000_0fff);
      sb.gain = wdata[GainW-1:0];
    end else begin
      wdata = ($urandom & 32'hffff_8000) | (value & 32'h0000_7fff);
      sb.limit = wdata[LimitW-1:0];
    end
    cfg_access(idx, 1'b1, wdata, rd);
    verify_reg(idx);
  endtask

  initial begin
    int unsigned gains[6];
    int unsigned limits[6];
    sb = new();
    gains  = '{0, 4095, 998, 256, $urandom_range(4095), $urandom_range(4095)};
    limits = '{32767, 1, 0, 8000, $urandom_range(32767), $urandom_range(1, 32767)};
    rst_n       = 1'b0;
    gaps_on     = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    verify_reg(REG_GAIN);
    verify_reg(REG_LIMIT);

    // directed, at the reset gain and limit
    send_cmd(mk(0, 0, 0));
    send_cmd(mk(32767, 0, 0));
    send_cmd(mk(-32768, 0, 0));
    send_cmd(mk(0, 32767, 0));
    send_cmd(mk(0, -32768, 0));
    send_cmd(mk(0, 0, 32767));
    send_cmd(mk(0, 0, -32768));
    send_cmd(mk(32767, 32767, 32767));
    send_cmd(mk(-32768, -32768, -32768));
    send_cmd(mk(32767, -32768, 32767));
    send_cmd(mk(-32768, 32767, -32768));
    send_cmd(mk(16384, 16384, 0));
    send_cmd(mk(100, 50, 10));
    send_cmd(mk(0, 0, 1));
    send_cmd(mk(0, 0, -1));
    send_cmd(mk(-1, 0, -1));
    send_cmd(mk(4000, 0, 0));
    send_cmd(mk(4001, 0, 0));
    send_cmd(mk(0, -4001, 0));
    send_cmd(mk(1000, -2000, 300));
    send_random(80);

    for (int p = 0; p < 6; p++) begin
      drain_pipeline();
      set_and_verify(REG_GAIN, gains[p]);
      set_and_verify(REG_LIMIT, limits[p]);
      // long stretch; both sides stream flat out only when p == 1, with random gaps otherwise
      gaps_on = (p != 1);
      send_cmd(mk(0, 0, 0));
      send_cmd(mk(32767, 32767, 32767));
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 2 && k == 35) drain_pipeline();
        send_cmd(mk(rand_speed(), rand_speed(), rand_speed()));
      end
    end
    gaps_on = 1'b1;

    drain_pipeline();
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mwm_pkg.sv
rtl/core/mwm_mix.sv
rtl/core/mwm_norm.sv
rtl/core/mwm_div.sv
rtl/core/mecanum_wheel_mixer_top.sv
bench/tb_mecanum_wheel_mixer_top.sv
